[src/double_ended_queue_assert.svh]
// Assertion macros shared by the deque RTL.
// Every macro samples on clk_i and is quiet while rst_ni is low.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTH

// Property checked on every edge outside reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every edge outside reset.
`define DQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DQ_ASSERT(lbl, prop, msg)
`define DQ_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

[src/dq_pkg.sv]
`default_nettype none

package dq_pkg;

  // Storage geometry
  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Fixed field widths
  localparam int DATA_W      = 32;
  localparam int REQ_W       = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESULT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;  // apply the request on the inputs
    logic read;  // fetch front and back words
  } dq_cmd_t;

  // Slot index base + off, modulo DEPTH; off must stay below DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/dq_datapath.sv]
`default_nettype none

`include "double_ended_queue_assert.svh"

module dq_datapath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire dq_pkg::dq_cmd_t                       cmd_i,
  input  wire logic [dq_pkg::REQ_W-1:0]              req_type_i,
  input  wire logic signed [dq_pkg::DATA_W-1:0]      push_value_i,
  output logic signed [dq_pkg::DATA_W-1:0]           front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0]           back_value_o,
  output logic [dq_pkg::COUNT_OUT_W-1:0]             entry_count_o,
  output logic                                       is_empty_o,
  output logic [dq_pkg::STATUS_W-1:0]                status_o
);

  // Pointer, count and status registers
  logic [dq_pkg::PTR_W-1:0] head_q, head_d;
  logic [dq_pkg::CNT_W-1:0] count_q, count_d;
  dq_pkg::status_e          status_q, status_d;

  // Entry store and registered read data
  logic [dq_pkg::DATA_W-1:0] mem_q [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0] rd_front_q, rd_back_q;

  logic                      wr_en;
  logic [dq_pkg::PTR_W-1:0]  wr_addr;
  logic [dq_pkg::PTR_W-1:0]  head_dec;
  logic [dq_pkg::PTR_W-1:0]  back_addr;
  logic [dq_pkg::CNT_W-1:0]  back_off;
  logic                      is_full;
  logic                      count_zero;
  logic                      req_push;
  dq_pkg::req_e              req;

  assign req        = dq_pkg::req_e'(req_type_i);
  assign req_push   = (req == dq_pkg::REQ_PUSH_FRONT) || (req == dq_pkg::REQ_PUSH_BACK);
  assign is_full    = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign count_zero = (count_q == '0);
  assign head_dec   = (head_q == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)
                                     : head_q - dq_pkg::PTR_W'(1);

  // Request execution: pointer update and store write
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = head_q;
    if (cmd_i.exec) begin
      status_d = dq_pkg::STAT_OK;
      case (req)
        dq_pkg::REQ_PUSH_FRONT: begin
          if (is_full) begin
            status_d = dq_pkg::STAT_PUSH_FULL;
          end else begin
            head_d  = head_dec;
            wr_en   = 1'b1;
            wr_addr = head_dec;
            count_d = count_q + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            status_d = dq_pkg::STAT_PUSH_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = dq_pkg::wrap_add(head_q, count_q);
            count_d = count_q + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::REQ_POP_FRONT: begin
          if (count_zero) begin
            status_d = dq_pkg::STAT_POP_EMPTY;
          end else begin
            head_d  = dq_pkg::wrap_add(head_q, dq_pkg::CNT_W'(1));
            count_d = count_q - dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::REQ_POP_BACK: begin
          if (count_zero) begin
            status_d = dq_pkg::STAT_POP_EMPTY;
          end else begin
            count_d = count_q - dq_pkg::CNT_W'(1);
          end
        end
        default: begin
          status_d = dq_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= dq_pkg::STAT_OK;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Back slot sits count-1 past the head
  assign back_off  = count_zero ? '0 : count_q - dq_pkg::CNT_W'(1);
  assign back_addr = dq_pkg::wrap_add(head_q, back_off);

  // Store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_value_i;
    end
    if (cmd_i.read) begin
      rd_front_q <= mem_q[head_q];
      rd_back_q  <= mem_q[back_addr];
    end
  end

  // Result fields; empty reads as zero
  assign front_value_o = count_zero ? '0 : rd_front_q;
  assign back_value_o  = count_zero ? '0 : rd_back_q;
  assign entry_count_o = dq_pkg::COUNT_OUT_W'(count_q);
  assign is_empty_o    = count_zero;
  assign status_o      = dq_pkg::STATUS_W'(status_q);

  `DQ_ASSERT(a_count_bound, count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH), "count above depth")
  `DQ_ASSERT_IMP(a_full_drop, cmd_i.exec && req_push && is_full,
                 $stable(count_q) && $stable(head_q) && status_q == dq_pkg::STAT_PUSH_FULL,
                 "push to full changed state")
  `DQ_ASSERT_IMP(a_empty_pop, cmd_i.exec && !req_push && count_zero,
                 count_q == '0 && status_q == dq_pkg::STAT_POP_EMPTY,
                 "pop from empty mishandled")

endmodule

`default_nettype wire

[src/dq_ctrl.sv]
`default_nettype none

`include "double_ended_queue_assert.svh"

module dq_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output dq_pkg::dq_cmd_t cmd_o
);

  dq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence: execute on accept, read store, hold result until transfer
  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      dq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = dq_pkg::S_READ;
        end
      end
      dq_pkg::S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = dq_pkg::S_RESULT;
      end
      dq_pkg::S_RESULT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  `DQ_ASSERT_IMP(a_exec_read, cmd_o.exec, cmd_o.read, "read does not follow execute")
  `DQ_ASSERT_IMP(a_read_result, cmd_o.read, out_valid_o, "result does not follow read")
  `DQ_ASSERT(a_one_item, !(out_valid_o && !in_stall_o), "input open while result pending")

endmodule

`default_nettype wire

[src/double_ended_queue.sv]
// Channel  Handshake                 Payload
// input    in_valid_i / in_stall_o   req_type_i, push_value_i
// output   out_valid_o / out_stall_i front_value_o, back_value_o, entry_count_o,
//                                    is_empty_o, status_o
//
// One request at a time, in the steps execute on transfer, store read and
// result; the store read is the registered two-port read of the entry store
// that follows the write.
// Output stalls hold the result and keep the input stalled.
// Reset clears head, count and status; the store needs no clearing.
`default_nettype none

module double_ended_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [dq_pkg::REQ_W-1:0]          req_type_i,
  input  wire logic signed [dq_pkg::DATA_W-1:0]  push_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [dq_pkg::DATA_W-1:0]       front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0]       back_value_o,
  output logic [dq_pkg::COUNT_OUT_W-1:0]         entry_count_o,
  output logic                                   is_empty_o,
  output logic [dq_pkg::STATUS_W-1:0]            status_o
);

  dq_pkg::dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire
